[src/olr_pkg.sv]
// Shared types and codes for the ordered list block.
`default_nettype none
package olr_pkg;

    // Operation codes carried in the mode field of an input word.
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LIST   = 2'd2;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_REMOVED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4,
        ST_ENTRY     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_REMOVE  = 2'd1,
        S_REM_FIN = 2'd2,
        S_LIST    = 2'd3
    } t_state;

    typedef enum logic [1:0] {
        EMIT_NONE   = 2'd0,
        EMIT_CODE   = 2'd1,
        EMIT_REMOVE = 2'd2,
        EMIT_ENTRY  = 2'd3
    } t_emit;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    ins_write;
        logic    rd;
        logic    cmp;
        t_emit   emit;
        t_status status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic pend;
        logic pend_last;
        logic rd_done;
        logic empty;
        logic full;
    } t_stat;

endpackage
`default_nettype wire

[src/olr_ctrl.sv]
// Controller state machine of the ordered list block.
`default_nettype none
module olr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_mode,
    input  wire olr_pkg::t_stat i_stat,
    output olr_pkg::t_cmd      o_cmd,
    output logic               o_ready
);

    olr_pkg::t_state r_state, n_state;
    logic            accept;

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            olr_pkg::S_IDLE: begin
                if (accept && !i_stat.empty &&
                    (i_mode == olr_pkg::MODE_REMOVE)) begin
                    n_state = olr_pkg::S_REMOVE;
                end else if (accept && !i_stat.empty &&
                             (i_mode == olr_pkg::MODE_LIST)) begin
                    n_state = olr_pkg::S_LIST;
                end
            end
            olr_pkg::S_REMOVE: begin
                if (i_stat.rd_done && !i_stat.pend) begin
                    n_state = olr_pkg::S_REM_FIN;
                end
            end
            olr_pkg::S_REM_FIN: begin
                if (i_stat.out_free) begin
                    n_state = olr_pkg::S_IDLE;
                end
            end
            olr_pkg::S_LIST: begin
                if (i_stat.pend && i_stat.out_free && i_stat.pend_last) begin
                    n_state = olr_pkg::S_IDLE;
                end
            end
            default: n_state = olr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            olr_pkg::S_IDLE: begin
                o_ready = i_stat.out_free;
                if (accept) begin
                    case (i_mode) inside
                        olr_pkg::MODE_INSERT: begin
                            o_cmd.emit = olr_pkg::EMIT_CODE;
                            if (i_stat.full) begin
                                o_cmd.status = olr_pkg::ST_FULL;
                            end else begin
                                o_cmd.ins_write = 1'b1;
                                o_cmd.status    = olr_pkg::ST_INSERTED;
                            end
                        end
                        olr_pkg::MODE_REMOVE, olr_pkg::MODE_LIST: begin
                            if (i_stat.empty) begin
                                o_cmd.emit   = olr_pkg::EMIT_CODE;
                                o_cmd.status = olr_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.capture = 1'b1;
                            end
                        end
                        default: o_cmd = '0;
                    endcase
                end
            end
            olr_pkg::S_REMOVE: begin
                o_cmd.rd  = !i_stat.rd_done;
                o_cmd.cmp = i_stat.pend;
            end
            olr_pkg::S_REM_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = olr_pkg::EMIT_REMOVE;
                end
            end
            olr_pkg::S_LIST: begin
                if (i_stat.pend && i_stat.out_free) begin
                    o_cmd.emit = olr_pkg::EMIT_ENTRY;
                end
                o_cmd.rd = !i_stat.rd_done &&
                           (!i_stat.pend || i_stat.out_free);
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[src/olr_dp.sv]
// Datapath of the ordered list block: entry memory, walk counters and result register.
`default_nettype none
module olr_dp #(
    parameter int CAPACITY = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic signed [31:0] i_value,
    input  wire olr_pkg::t_cmd      i_cmd,
    output olr_pkg::t_stat          o_stat,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [2:0]              o_status,
    output logic signed [31:0]      o_entry_value,
    output logic [4:0]              o_removed_count,
    output logic                    o_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [31:0]   mem [CAPACITY];

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rd_idx;
    logic [CW-1:0] r_kept;
    logic          r_pend;
    logic          r_pend_last;
    logic [31:0]   r_rdata;
    logic [31:0]   r_value;

    logic          r_out_valid;
    logic [2:0]    r_status;
    logic [31:0]   r_entry;
    logic [4:0]    r_removed;
    logic          r_last;

    logic          out_free;
    logic          keep;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [CW-1:0] diff;
    logic [31:0]   diff_w;

    assign out_free = !r_out_valid || i_ready;
    assign keep     = i_cmd.cmp && (r_rdata != r_value);
    assign diff     = r_count - r_kept;
    assign diff_w   = 32'(diff);

    assign o_stat.out_free  = out_free;
    assign o_stat.pend      = r_pend;
    assign o_stat.pend_last = r_pend_last;
    assign o_stat.rd_done   = (r_rd_idx == r_count);
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CW'(CAPACITY));

    // One write port: appends on insert, compacts surviving entries on remove.
    always_comb begin
        wr_en   = i_cmd.ins_write || keep;
        wr_addr = i_cmd.ins_write ? r_count[AW-1:0] : r_kept[AW-1:0];
        wr_data = i_cmd.ins_write ? i_value : r_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= mem[r_rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_value <= i_value;
        end
        if (i_cmd.rd) begin
            r_pend_last <= ((r_rd_idx + CW'(1)) == r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_idx <= '0;
            r_kept   <= '0;
            r_pend   <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_rd_idx <= '0;
                r_kept   <= '0;
                r_pend   <= 1'b0;
            end else begin
                if (i_cmd.rd) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                    r_pend   <= 1'b1;
                end else if (i_cmd.cmp || (i_cmd.emit == olr_pkg::EMIT_ENTRY)) begin
                    r_pend   <= 1'b0;
                end
                if (keep) begin
                    r_kept <= r_kept + CW'(1);
                end
            end
            if (i_cmd.ins_write) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.emit == olr_pkg::EMIT_REMOVE) begin
                r_count <= r_kept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit != olr_pkg::EMIT_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.emit)
            olr_pkg::EMIT_CODE: begin
                r_status  <= i_cmd.status;
                r_entry   <= '0;
                r_removed <= '0;
                r_last    <= 1'b1;
            end
            olr_pkg::EMIT_REMOVE: begin
                r_status  <= (diff == '0) ? olr_pkg::ST_NOT_FOUND : olr_pkg::ST_REMOVED;
                r_entry   <= '0;
                r_removed <= (diff_w > 32'd31) ? 5'd31 : diff_w[4:0];
                r_last    <= 1'b1;
            end
            olr_pkg::EMIT_ENTRY: begin
                r_status  <= olr_pkg::ST_ENTRY;
                r_entry   <= r_rdata;
                r_removed <= '0;
                r_last    <= r_pend_last;
            end
            default: begin
                r_status  <= r_status;
            end
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_entry_value   = r_entry;
    assign o_removed_count = r_removed;
    assign o_last          = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_kept_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= r_rd_idx)
        else $error("compaction pointer ran ahead of the read pointer");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_rd_idx < r_count))
        else $error("read issued beyond the stored entries");

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit != olr_pkg::EMIT_NONE) |-> out_free)
        else $error("result loaded over a word still waiting");

endmodule
`default_nettype wire

[src/ordered_list_remove_by_value.sv]
// Top level of the ordered list block: controller and datapath joined by command and status.
//
// Usage: input words (mode, value) arrive on a valid/ready channel; result words
// (status, entry_value, removed_count, last) leave on another valid/ready channel
// through an output register. A word is moved when valid and ready are both high.
// Insert appends at the tail (or reports full); its result is registered at the accepting
// edge itself, and the next word can be accepted in the following cycle if the receiver
// takes the result. Remove walks every stored entry through the single read port of the
// entry memory, compacting survivors in place; its result is registered after the walk.
// List reads the entries head to tail; the first entry is registered once read from memory,
// and further entries follow one per cycle while the receiver keeps ready high. An empty
// list gives a single word with the empty status. A mode of three is dropped with no
// result. Every operation delivers its final word with last set.
// When the receiver stalls, the output register holds its word and the walk pauses;
// no new input word is taken until the current operation has produced all its
// results and the output register can take another.
// Reset (synchronous, active low) empties the list at once by clearing the entry
// count; the memory contents need no clearing pass.
`default_nettype none
module ordered_list_remove_by_value #(
    parameter int CAPACITY = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_mode,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [2:0]              o_status,
    output logic signed [31:0]      o_entry_value,
    output logic [4:0]              o_removed_count,
    output logic                    o_last
);

    // Commands flow from the controller; status flows back from the datapath.
    olr_pkg::t_cmd  cmd;
    olr_pkg::t_stat stat;

    olr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_ready (o_ready)
    );

    olr_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_value         (i_value),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_entry_value   (o_entry_value),
        .o_removed_count (o_removed_count),
        .o_last          (o_last)
    );

endmodule
`default_nettype wire
